FILE: sv/skf_pkg.sv
`timescale 1ns / 1ps
package skf_pkg;
  localparam int unsigned FracBits = 16;
  localparam int unsigned CovW = 24;
  localparam int unsigned SmpW = 32;
  localparam int unsigned GainW = FracBits + 1;
  localparam int unsigned QuoW = CovW + FracBits + 1;
  localparam int unsigned DivCnt = GainW;
  localparam int unsigned CntW = $clog2(DivCnt + 1);
  localparam logic [CovW-1:0] CovMax = {CovW{1'b1}};
  localparam logic [CovW-1:0] TenthFx = CovW'((2 * (1 << FracBits) / 10 + 1) / 2);
  localparam logic [1:0] RegProcNoise = 2'd0;
  localparam logic [1:0] RegMeasNoise = 2'd1;
  localparam logic [1:0] RegStartEst = 2'd2;
  localparam logic [1:0] RegStartErr = 2'd3;

  typedef enum logic [2:0] {
    StIdle, StPred, StDiv, StMul, StProd, StUpd, StOut
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic pred;
    logic div_init;
    logic div_step;
    logic mul;
    logic prod;
    logic upd;
    logic out_load;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic den_zero;
  } status_t;
endpackage

FILE: sv/skf_ctrl.sv
`timescale 1ns / 1ps
module skf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_busy_i,
  input  skf_pkg::status_t status_i,
  output skf_pkg::cmd_t   cmd_o
);
  import skf_pkg::*;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  // Sequencing of one item through the shared divider and multiply steps.
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StPred;
        end
      end
      StPred: begin
        cmd_o.pred = 1'b1;
        state_d = StDiv;
        cnt_d = '0;
      end
      StDiv: begin
        if (cnt_q == '0) begin
          // A zero denominator needs no division.
          if (status_i.den_zero) begin
            state_d = StMul;
          end else begin
            cmd_o.div_init = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
        end else begin
          cmd_o.div_step = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CntW'(DivCnt)) state_d = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d = StProd;
      end
      StProd: begin
        cmd_o.prod = 1'b1;
        state_d = StUpd;
      end
      StUpd: begin
        cmd_o.upd = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (!out_busy_i) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end
endmodule

FILE: sv/skf_dp.sv
`timescale 1ns / 1ps
module skf_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  skf_pkg::cmd_t                 cmd_i,
  output skf_pkg::status_t              status_o,
  input  logic signed [skf_pkg::SmpW-1:0] meas_i,
  input  logic                          restart_i,
  input  logic [skf_pkg::CovW-1:0]      q_i,
  input  logic [skf_pkg::CovW-1:0]      r_i,
  input  logic signed [skf_pkg::SmpW-1:0] start_est_i,
  input  logic [skf_pkg::CovW-1:0]      start_err_i,
  output logic signed [skf_pkg::SmpW-1:0] est_o,
  output logic [skf_pkg::GainW-1:0]     gain_o,
  output logic                          err_o
);
  import skf_pkg::*;

  logic signed [SmpW-1:0] est_q, meas_q;
  logic [CovW-1:0] cov_q, p1_q;
  logic [CovW:0] den_q;
  logic err_q;
  logic [QuoW-1:0] num_q;
  logic [CovW+1:0] rem_q;
  logic [GainW-1:0] k_q;
  logic signed [SmpW+GainW+1:0] adj_q;
  logic [CovW+GainW-1:0] pc_q;

  logic [CovW:0] p1_sum;
  logic [CovW+1:0] rem_sh;
  logic [QuoW-1:0] quo;
  logic signed [SmpW:0] diff;
  logic signed [SmpW+1:0] nx;
  logic [GainW-1:0] kc;

  assign p1_sum = {1'b0, cov_q} + {1'b0, q_i};
  assign status_o.den_zero = (den_q == '0);
  assign rem_sh = {rem_q[CovW:0], num_q[QuoW-1]};
  assign diff = {meas_q[SmpW-1], meas_q} - {est_q[SmpW-1], est_q};
  assign nx = {{2{est_q[SmpW-1]}}, est_q} + (SmpW+2)'(adj_q >>> FracBits);
  assign quo = num_q;
  assign kc = k_q;

  // Filter state, sticky flag and restart reload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= '0;
      cov_q <= TenthFx;
      err_q <= 1'b0;
    end else if (cmd_i.load && restart_i) begin
      est_q <= start_est_i;
      cov_q <= start_err_i;
      err_q <= 1'b0;
    end else if (cmd_i.upd) begin
      if (den_q == '0) begin
        err_q <= 1'b1;
        cov_q <= '0;
      end else begin
        // Saturate when the top three bits of the sum disagree.
        if (nx[SmpW+1:SmpW-1] != {3{nx[SmpW+1]}}) begin
          est_q <= nx[SmpW+1] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
          est_q <= nx[SmpW-1:0];
        end
        cov_q <= pc_q[FracBits +: CovW];
      end
    end
  end

  // Prediction, restoring divider and gain.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) meas_q <= meas_i;
    if (cmd_i.pred) begin
      p1_q <= p1_sum[CovW] ? CovMax : p1_sum[CovW-1:0];
      den_q <= (p1_sum[CovW] ? {1'b0, CovMax} : p1_sum) + {1'b0, r_i};
      k_q <= '0;
    end
    if (cmd_i.div_init) begin
      // Since p <= p + r the quotient has at most GainW bits, so the
      // remainder starts from the numerator's upper bits and the last
      // numerator bit is shifted in by the first step.
      num_q <= {p1_q[0], (QuoW-1)'(0)};
      rem_q <= {3'b0, p1_q[CovW-1:1]};
    end
    if (cmd_i.div_step) begin
      // One quotient bit per cycle.
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        num_q <= {num_q[QuoW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        num_q <= {num_q[QuoW-2:0], 1'b0};
      end
    end
    if (cmd_i.mul) begin
      if (den_q == '0) k_q <= '0;
      else if (quo > QuoW'(1 << FracBits)) k_q <= GainW'(1 << FracBits);
      else k_q <= quo[GainW-1:0];
    end
  end

  // Gain products, registered before the update.
  logic [GainW-1:0] onem;
  assign onem = GainW'(1 << FracBits) - kc;
  always_ff @(posedge clk_i) begin
    if (cmd_i.prod) begin
      adj_q <= $signed({1'b0, kc}) * diff;
      pc_q <= onem * p1_q;
    end
  end

  assign est_o = est_q;
  assign gain_o = k_q;
  assign err_o = err_q;
endmodule

FILE: sv/scalar_kalman_filter.sv
`timescale 1ns / 1ps
// Scalar Kalman filter. Each item on the s_axis side carries one signed Q16.16
// measurement, a restart flag in tuser and an end-of-block mark in tlast; one
// result item with the new estimate, the gain and the sticky error flag leaves
// on m_axis. An item passes from accept through prediction, the divider (a
// load and 17 quotient bits), gain, product, update and output load before
// the next item is accepted. The gain p/(p+r) comes from a restoring divider
// that yields one quotient bit per cycle. With a zero denominator the divider
// is skipped. The result waits in an output register, so a stalled sink holds
// the next item only at its final step. Registers are written over APB at
// 4*index.
module scalar_kalman_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // measurement
  input  logic        s_axis_tuser,   // restart
  input  logic        s_axis_tlast,   // last_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // estimate[31:0], gain[48:32], zero fill
  output logic        m_axis_tuser,   // error_seen
  output logic        m_axis_tlast    // block_end
);
  import skf_pkg::*;

  logic [CovW-1:0] q_q, r_q, serr_q;
  logic [SmpW-1:0] sest_q;
  logic last_q;
  logic ovalid_q;
  logic [SmpW-1:0] oest_q;
  logic [GainW-1:0] ogain_q;
  logic oerr_q, olast_q;
  cmd_t cmd;
  status_t status;
  logic signed [SmpW-1:0] est;
  logic [GainW-1:0] gain;
  logic err;
  logic [1:0] ridx;

  assign pready = 1'b1;
  assign ridx = paddr[3:2];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= TenthFx;
      r_q <= TenthFx;
      sest_q <= '0;
      serr_q <= TenthFx;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        RegProcNoise: q_q <= pwdata[CovW-1:0];
        RegMeasNoise: r_q <= pwdata[CovW-1:0];
        RegStartEst:  sest_q <= pwdata;
        RegStartErr:  serr_q <= pwdata[CovW-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (ridx)
      RegProcNoise: prdata = {8'd0, q_q};
      RegMeasNoise: prdata = {8'd0, r_q};
      RegStartEst:  prdata = sest_q;
      RegStartErr:  prdata = {8'd0, serr_q};
      default:      prdata = '0;
    endcase
  end

  // Side field of the item in flight.
  always_ff @(posedge clk_i) begin
    if (cmd.load) begin
      last_q <= s_axis_tlast;
    end
  end

  skf_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .out_busy_i(ovalid_q && !m_axis_tready),
    .status_i(status),
    .cmd_o(cmd)
  );

  skf_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd),
    .status_o(status),
    .meas_i(s_axis_tdata),
    .restart_i(s_axis_tuser),
    .q_i(q_q), .r_i(r_q),
    .start_est_i(sest_q), .start_err_i(serr_q),
    .est_o(est), .gain_o(gain), .err_o(err)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (cmd.out_load) ovalid_q <= 1'b1;
    else if (m_axis_tready) ovalid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      oest_q <= est;
      ogain_q <= gain;
      oerr_q <= err;
      olast_q <= last_q;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {7'd0, ogain_q, oest_q};
  assign m_axis_tuser = oerr_q;
  assign m_axis_tlast = olast_q;
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import skf_pkg::*;

  // Register addresses (4*index) of the configuration port.
  localparam logic [3:0] AddrProcNoise = 4'({RegProcNoise, 2'b00});
  localparam logic [3:0] AddrMeasNoise = 4'({RegMeasNoise, 2'b00});
  localparam logic [3:0] AddrStartEst = 4'({RegStartEst, 2'b00});
  localparam logic [3:0] AddrStartErr = 4'({RegStartErr, 2'b00});
  localparam longint CycleLimit = 3000000;

  typedef struct packed {
    logic [31:0] estimate;
    logic [16:0] gain;
    logic        error_seen;
    logic        block_end;
  } filter_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // measurement
  logic s_axis_tuser = 1'b0;       // restart
  logic s_axis_tlast = 1'b0;       // last_sample
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;       // estimate[31:0], gain[48:32], zero fill
  logic m_axis_tuser;              // error_seen
  logic m_axis_tlast;              // block_end

  int mismatches = 0;
  longint cycles = 0;
  bit sink_on = 1'b0;

  task automatic report_mismatch(string what, longint want, longint got);
    $display("mismatch %s: expected %0h got %0h at cycle %0d", what, want, got, cycles);
    mismatches++;
  endtask

  // Scoreboard: a copy of the filter state and the queue of expected results.
  class filter_scoreboard;
    logic [23:0] q_noise, r_noise, p_start;
    logic [31:0] x_start;
    logic signed [31:0] est;
    logic [23:0] cov;
    logic sticky;
    filter_out_t pending[$];

    function void init();
      q_noise = TenthFx; r_noise = TenthFx; p_start = TenthFx; x_start = '0;
      est = '0; cov = TenthFx; sticky = 1'b0;
    endfunction

    function void write_reg(logic [3:0] addr, logic [31:0] val);
      case (addr)
        AddrProcNoise: q_noise = val[23:0];
        AddrMeasNoise: r_noise = val[23:0];
        AddrStartEst: x_start = val;
        AddrStartErr: p_start = val[23:0];
        default: ;
      endcase
    endfunction

    // Predicts the result of one accepted measurement.
    function void note_sample(logic [31:0] meas, logic restart, logic last);
      logic [25:0] p1, den;
      logic [63:0] k;
      longint diff, prod, adj, nx;
      filter_out_t r;
      if (restart) begin
        est = x_start; cov = p_start; sticky = 1'b0;
      end
      p1 = {2'b0, cov} + {2'b0, q_noise};
      if (p1 > 26'hFFFFFF) p1 = 26'hFFFFFF;
      den = p1 + {2'b0, r_noise};
      k = 0;
      if (den == 0) begin
        sticky = 1'b1;
        cov = '0;
      end else begin
        k = ({38'b0, p1} << FracBits) / {38'b0, den};
        if (k > (64'd1 << FracBits)) k = 64'd1 << FracBits;
        diff = longint'($signed(meas)) - longint'(est);
        prod = longint'(k) * diff;
        adj = prod >>> FracBits;
        nx = longint'(est) + adj;
        if (nx > 64'sd2147483647) nx = 64'sd2147483647;
        if (nx < -64'sd2147483648) nx = -64'sd2147483648;
        est = nx[31:0];
        cov = 24'(((((64'd1 << FracBits) - k) * {38'b0, p1}) >> FracBits));
      end
      r.estimate = est;
      r.gain = k[16:0];
      r.error_seen = sticky;
      r.block_end = last;
      pending.push_back(r);
    endfunction

    // Compares one received result with the oldest expectation.
    task check_result(filter_out_t got);
      filter_out_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with no expectation", 0, got.estimate);
        return;
      end
      want = pending.pop_front();
      if (got.estimate !== want.estimate)
        report_mismatch("estimate", want.estimate, got.estimate);
      if (got.gain !== want.gain) report_mismatch("gain", want.gain, got.gain);
      if (got.error_seen !== want.error_seen)
        report_mismatch("error_seen", want.error_seen, got.error_seen);
      if (got.block_end !== want.block_end)
        report_mismatch("block_end", want.block_end, got.block_end);
    endtask
  endclass

  filter_scoreboard board;

  scalar_kalman_filter dut (.*);

  always #1 clk_i = ~clk_i;

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("scalar_kalman_filter regression: fail");
      $finish;
    end
  end

  // Result sink with random stalls drawn per item.
  initial begin : sink
    int wait_n;
    filter_out_t got;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.estimate = m_axis_tdata[31:0];
        got.gain = m_axis_tdata[48:32];
        got.error_seen = m_axis_tuser;
        got.block_end = m_axis_tlast;
        board.check_result(got);
        wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (wait_n > 0) begin
          m_axis_tready <= 1'b0;
          repeat (wait_n) @(posedge clk_i);
        end
      end
      m_axis_tready <= sink_on;
    end
  end

  task automatic apb_write(logic [3:0] addr, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    board.write_reg(addr, val);
  endtask

  // Offers one item; tvalid stays high into a back-to-back follower.
  task automatic send_sample(logic [31:0] meas, logic restart, logic last);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1; s_axis_tdata <= meas;
    s_axis_tuser <= restart; s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_sample(meas, restart, last);
  endtask

  // Waits until every expected result has arrived, plus the block latency.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [23:0] q, logic [23:0] r, logic [31:0] x, logic [23:0] p);
    apb_write(AddrProcNoise, {8'b0, q});
    apb_write(AddrMeasNoise, {8'b0, r});
    apb_write(AddrStartEst, x);
    apb_write(AddrStartErr, {8'b0, p});
  endtask

  function automatic logic [31:0] rand_meas();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      2: return ($urandom_range(0, 1) != 0) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $urandom() & 32'h000FFFFF;
    endcase
  endfunction

  function automatic logic [23:0] rand_cov();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom());
      default: return 24'($urandom_range(0, 1 << 17));
    endcase
  endfunction

  initial begin : stimulus
    board = new();
    board.init();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    sink_on = 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset values and extreme measurements.
    send_sample(32'h7FFFFFFF, 1'b0, 1'b0);
    send_sample(32'h80000000, 1'b0, 1'b0);
    send_sample(32'h00010000, 1'b1, 1'b1);
    send_sample(32'hFFFFFFFF, 1'b0, 1'b0);
    drain();
    // Zero denominator, then recovery by restart.
    set_regs(24'h0, 24'h0, 32'h00050000, 24'h0);
    send_sample(32'h00030000, 1'b1, 1'b0);
    send_sample(32'h7FFFFFFF, 1'b0, 1'b1);
    drain();
    // Gain of one: r zero with p nonzero.
    set_regs(24'h000100, 24'h0, 32'h80000000, 24'h010000);
    send_sample(32'h7FFFFFFF, 1'b1, 1'b0);
    send_sample(32'h12345678, 1'b0, 1'b1);
    drain();
    // Covariance overflow with saturating estimates.
    set_regs(24'hFFFFFF, 24'hFFFFFF, 32'h7FFFFFFF, 24'hFFFFFF);
    send_sample(32'h80000000, 1'b1, 1'b0);
    send_sample(32'h7FFFFFFF, 1'b0, 1'b0);
    send_sample(32'h80000000, 1'b0, 1'b1);
    drain();
    set_regs(24'h0, 24'hFFFFFF, 32'h0, 24'h0);
    send_sample(32'h7FFFFFFF, 1'b1, 1'b1);
    drain();

    // Random phases with fresh settings between them.
    for (int ph = 0; ph < 28; ph++) begin
      set_regs(rand_cov(), rand_cov(), rand_meas(), rand_cov());
      for (int n = 0; n < 50; n++)
        send_sample(rand_meas(), ($urandom_range(0, 15) == 0), ($urandom_range(0, 7) == 0));
      drain();
    end

    // Hold off until all results are in, then close the run.
    drain();
    if (mismatches == 0) begin
      $display("scalar_kalman_filter regression: pass");
    end else begin
      $display("scalar_kalman_filter regression: fail");
    end
    $finish;
  end
endmodule
